@@ rtl/iprf_pkg.sv @@
// Package for the IPv4 prefix rule filter: sizes, codes and the rule entry type.
// No dependencies; every other file of the block imports it.
package iprf_pkg;

  localparam int RULE_SLOTS   = 32;
  localparam int COUNTER_BITS = 48;
  localparam int HIT_SLOTS    = RULE_SLOTS + 1;
  localparam int RULE_IDX_W   = $clog2(RULE_SLOTS);
  localparam int HIT_IDX_W    = $clog2(HIT_SLOTS);

  // Field widths
  localparam int SLOT_W   = 6;
  localparam int PREFIX_W = 6;
  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 16;
  localparam int ETYPE_W  = 16;
  localparam int HITS_W   = 48;
  localparam int BYTES_W  = 64;

  // Operation codes
  localparam logic [1:0] OP_CLASSIFY   = 2'd0;
  localparam logic [1:0] OP_WRITE_RULE = 2'd1;
  localparam logic [1:0] OP_READ_HITS  = 2'd2;

  localparam logic [ETYPE_W-1:0] ETHER_IPV4 = 16'h0800;

  // Slot codes reported in matched_slot
  localparam logic [SLOT_W-1:0] SLOT_DEFAULT = SLOT_W'(RULE_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_NONE    = SLOT_W'(RULE_SLOTS + 1);

  localparam logic [PREFIX_W-1:0] PREFIX_FULL = PREFIX_W'(32);

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_RULE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_DROP      = CFG_IDX_W'(1);

  localparam logic [COUNTER_BITS-1:0] COUNT_MAX = {COUNTER_BITS{1'b1}};

  // One stored rule
  typedef struct packed {
    logic [ADDR_W-1:0]   src_net;
    logic [ADDR_W-1:0]   dst_net;
    logic [PREFIX_W-1:0] src_prefix;
    logic [PREFIX_W-1:0] dst_prefix;
    logic                drops;
  } rule_entry_t;

  // Compare outcome of the rule read last cycle
  typedef struct packed {
    logic hit;
    logic drops;
  } rule_match_t;

endpackage

@@ rtl/iprf_in_if.sv @@
// Input channel of the IPv4 prefix rule filter: valid/ready plus one item.
// Depends on iprf_pkg.
interface iprf_in_if import iprf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [ETYPE_W-1:0]  frame_type;
  logic [ADDR_W-1:0]   source_address;
  logic [ADDR_W-1:0]   dest_address;
  logic [LEN_W-1:0]    packet_length;
  logic [SLOT_W-1:0]   slot_index;
  logic [ADDR_W-1:0]   rule_src_net;
  logic [PREFIX_W-1:0] rule_src_prefix;
  logic [ADDR_W-1:0]   rule_dst_net;
  logic [PREFIX_W-1:0] rule_dst_prefix;
  logic                rule_drops;

  modport source (output valid, operation, frame_type, source_address, dest_address,
                  packet_length, slot_index, rule_src_net, rule_src_prefix,
                  rule_dst_net, rule_dst_prefix, rule_drops,
                  input ready);
  modport sink (input valid, operation, frame_type, source_address, dest_address,
                packet_length, slot_index, rule_src_net, rule_src_prefix,
                rule_dst_net, rule_dst_prefix, rule_drops,
                output ready);
endinterface

@@ rtl/iprf_out_if.sv @@
// Result channel of the IPv4 prefix rule filter: valid/ready plus one result.
// Depends on iprf_pkg.
interface iprf_out_if import iprf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               drop_packet;
  logic [SLOT_W-1:0]  matched_slot;
  logic [HITS_W-1:0]  hit_count;
  logic [HITS_W-1:0]  passed_packets;
  logic [BYTES_W-1:0] passed_bytes;
  logic [HITS_W-1:0]  dropped_packets;

  modport source (output valid, drop_packet, matched_slot, hit_count, passed_packets,
                  passed_bytes, dropped_packets, input ready);
  modport sink (input valid, drop_packet, matched_slot, hit_count, passed_packets,
                passed_bytes, dropped_packets, output ready);
endinterface

@@ rtl/iprf_cfg_if.sv @@
// Configuration write channel of the IPv4 prefix rule filter.
// Depends on iprf_pkg.
interface iprf_cfg_if import iprf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] reg_data;

  modport source (output valid, reg_index, reg_data, input ready);
  modport sink (input valid, reg_index, reg_data, output ready);
endinterface

@@ rtl/iprf_rule_table.sv @@
// Rule table: synchronous memory of rule entries with a registered read port,
// and the prefix-masked compare of the entry just read. Depends on iprf_pkg.
module iprf_rule_table import iprf_pkg::*; (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [RULE_IDX_W-1:0] wr_addr,
  input  rule_entry_t           wr_entry,
  input  logic                  rd_en,
  input  logic [RULE_IDX_W-1:0] rd_addr,
  input  logic [ADDR_W-1:0]     pkt_src,
  input  logic [ADDR_W-1:0]     pkt_dst,
  output rule_match_t           match
);

  rule_entry_t rule_mem [RULE_SLOTS];
  rule_entry_t rd_entry_r;

  // Prefix length to network mask; lengths above 32 count as 32
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] prefix);
    logic [PREFIX_W-1:0] len;
    len = (prefix > PREFIX_FULL) ? PREFIX_FULL : prefix;
    if (len == '0) begin
      prefix_mask = '0;
    end else begin
      prefix_mask = {ADDR_W{1'b1}} << (PREFIX_FULL - len);
    end
  endfunction

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule_mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry_r <= rule_mem[rd_addr];
    end
  end

  // Stored nets are compared unmasked, so host bits in a net never match
  always_comb begin
    match.hit = ((pkt_src & prefix_mask(rd_entry_r.src_prefix)) == rd_entry_r.src_net) &&
                ((pkt_dst & prefix_mask(rd_entry_r.dst_prefix)) == rd_entry_r.dst_net);
    match.drops = rd_entry_r.drops;
  end

endmodule

@@ rtl/ipv4_prefix_rule_filter.sv @@
// Top level of the IPv4 prefix rule filter: sequencer, hit counter memory,
// saturating totals and output register. Depends on iprf_pkg, the channel
// interfaces and iprf_rule_table.
//
//  channel  | direction | handshake    | carries
//  ---------+-----------+--------------+------------------------------------
//  in_ch    | sink      | valid/ready  | classify, rule write or hit read
//  out_ch   | source    | valid/ready  | action, slot, hit count, totals
//  cfg_ch   | sink      | valid/ready  | register index and data, always ready
//
// One transaction at a time. A classify walks the rule table one entry a cycle
// through the table's read port, then reads, increments and writes back the
// hit counter. The output register lets the next item in while a result
// waits; a stalled output holds the sequencer in its last state. Synchronous
// active-low reset clears counters, totals and registers.
module ipv4_prefix_rule_filter import iprf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  iprf_in_if.sink    in_ch,
  iprf_out_if.source out_ch,
  iprf_cfg_if.sink   cfg_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_HIT,
    S_HUPD,
    S_HRD,
    S_TOT,
    S_DONE
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [SLOT_W-1:0] active_rule_count_r;
  logic              default_drop_r;

  // Work registers of the item in progress
  logic [ADDR_W-1:0]     src_r;
  logic [ADDR_W-1:0]     dst_r;
  logic [LEN_W-1:0]      len_r;
  logic                  drop_r;
  logic [SLOT_W-1:0]     matched_r;
  logic [HITS_W-1:0]     hits_r;
  logic [RULE_IDX_W-1:0] idx_r;
  logic [RULE_IDX_W-1:0] last_idx_r;

  // Totals
  logic [COUNTER_BITS-1:0] passed_total_r;
  logic [BYTES_W-1:0]      passed_bytes_r;
  logic [COUNTER_BITS-1:0] dropped_total_r;

  // Output register
  logic               out_valid_r;
  logic               out_drop_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [HITS_W-1:0]  out_hits_r;
  logic [HITS_W-1:0]  out_passed_r;
  logic [BYTES_W-1:0] out_bytes_r;
  logic [HITS_W-1:0]  out_dropped_r;

  // Hit counter memory with per-entry valid bits
  logic [COUNTER_BITS-1:0] hit_mem [HIT_SLOTS];
  logic [HIT_SLOTS-1:0]    hit_vld_r;
  logic [COUNTER_BITS-1:0] hit_rd_data_r;
  logic                    hit_rd_vld_r;
  logic                    hit_re;
  logic [HIT_IDX_W-1:0]    hit_raddr;
  logic                    hit_we;
  logic [COUNTER_BITS-1:0] hit_wdata;

  logic                  in_acc;
  logic                  is_ipv4;
  logic [SLOT_W-1:0]     scan_n;
  logic                  rule_we;
  logic                  rule_re;
  logic [RULE_IDX_W-1:0] rule_raddr;
  rule_entry_t           rule_wentry;
  rule_match_t           rule_match;
  logic                  scan_last;
  logic                  out_free;
  logic [BYTES_W:0]      bytes_sum;

  function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign is_ipv4      = (in_ch.frame_type == ETHER_IPV4);
  assign scan_n       = (active_rule_count_r > SLOT_DEFAULT) ? SLOT_DEFAULT
                                                             : active_rule_count_r;
  assign scan_last    = (idx_r == last_idx_r);
  assign out_free     = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign bytes_sum    = {1'b0, passed_bytes_r} + {{(BYTES_W + 1 - LEN_W){1'b0}}, len_r};

  // Rule table write on acceptance of an in-range rule write
  assign rule_we = in_acc && (in_ch.operation == OP_WRITE_RULE) &&
                   (in_ch.slot_index < SLOT_DEFAULT);
  always_comb begin
    rule_wentry.src_net    = in_ch.rule_src_net;
    rule_wentry.dst_net    = in_ch.rule_dst_net;
    rule_wentry.src_prefix = in_ch.rule_src_prefix;
    rule_wentry.dst_prefix = in_ch.rule_dst_prefix;
    rule_wentry.drops      = in_ch.rule_drops;
  end

  // Rule read: slot 0 at acceptance, then the next slot while no match
  always_comb begin
    rule_re    = 1'b0;
    rule_raddr = '0;
    if (in_acc && (in_ch.operation == OP_CLASSIFY) && is_ipv4 && (scan_n != '0)) begin
      rule_re = 1'b1;
    end else if ((state_r == S_SCAN) && !rule_match.hit && !scan_last) begin
      rule_re    = 1'b1;
      rule_raddr = idx_r + 1'b1;
    end
  end

  iprf_rule_table u_rule_table (
    .clk      (clk),
    .wr_en    (rule_we),
    .wr_addr  (in_ch.slot_index[RULE_IDX_W-1:0]),
    .wr_entry (rule_wentry),
    .rd_en    (rule_re),
    .rd_addr  (rule_raddr),
    .pkt_src  (src_r),
    .pkt_dst  (dst_r),
    .match    (rule_match)
  );

  // Hit counter read and write-back
  always_comb begin
    hit_re    = 1'b0;
    hit_raddr = matched_r[HIT_IDX_W-1:0];
    if (in_acc && (in_ch.operation == OP_READ_HITS) && (in_ch.slot_index <= SLOT_DEFAULT)) begin
      hit_re    = 1'b1;
      hit_raddr = in_ch.slot_index[HIT_IDX_W-1:0];
    end else if (state_r == S_HIT) begin
      hit_re = 1'b1;
    end
  end

  assign hit_we    = (state_r == S_HUPD);
  assign hit_wdata = sat_inc(hit_rd_vld_r ? hit_rd_data_r : '0);

  always_ff @(posedge clk) begin
    if (hit_we) begin
      hit_mem[matched_r[HIT_IDX_W-1:0]] <= hit_wdata;
    end
    if (hit_re) begin
      hit_rd_data_r <= hit_mem[hit_raddr];
    end
  end

  // Valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_vld_r    <= '0;
      hit_rd_vld_r <= 1'b0;
    end else begin
      if (hit_we) begin
        hit_vld_r[matched_r[HIT_IDX_W-1:0]] <= 1'b1;
      end
      if (hit_re) begin
        hit_rd_vld_r <= hit_vld_r[hit_raddr];
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_rule_count_r <= '0;
      default_drop_r      <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.reg_index)
        CFG_ACTIVE_RULE_COUNT: active_rule_count_r <= cfg_ch.reg_data[SLOT_W-1:0];
        CFG_DEFAULT_DROP:      default_drop_r      <= cfg_ch.reg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer, totals and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      passed_total_r  <= '0;
      passed_bytes_r  <= '0;
      dropped_total_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      // result leaves on its handshake; S_DONE reloads it in the same cycle
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            src_r      <= in_ch.source_address;
            dst_r      <= in_ch.dest_address;
            len_r      <= in_ch.packet_length;
            idx_r      <= '0;
            last_idx_r <= RULE_IDX_W'(scan_n - 1'b1);
            drop_r     <= 1'b0;
            matched_r  <= SLOT_NONE;
            hits_r     <= '0;
            case (in_ch.operation)
              OP_CLASSIFY: begin
                if (!is_ipv4) begin
                  drop_r  <= default_drop_r;
                  state_r <= S_TOT;
                end else if (scan_n == '0) begin
                  drop_r    <= default_drop_r;
                  matched_r <= SLOT_DEFAULT;
                  state_r   <= S_HIT;
                end else begin
                  state_r <= S_SCAN;
                end
              end
              OP_READ_HITS: begin
                state_r <= (in_ch.slot_index <= SLOT_DEFAULT) ? S_HRD : S_DONE;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (rule_match.hit) begin
            drop_r    <= rule_match.drops;
            matched_r <= SLOT_W'(idx_r);
            state_r   <= S_HIT;
          end else if (scan_last) begin
            drop_r    <= default_drop_r;
            matched_r <= SLOT_DEFAULT;
            state_r   <= S_HIT;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_HIT: begin
          state_r <= S_HUPD;
        end
        S_HUPD: begin
          state_r <= S_TOT;
        end
        S_HRD: begin
          hits_r  <= hit_rd_vld_r ? HITS_W'(hit_rd_data_r) : '0;
          state_r <= S_DONE;
        end
        S_TOT: begin
          if (drop_r) begin
            dropped_total_r <= sat_inc(dropped_total_r);
          end else begin
            passed_total_r <= sat_inc(passed_total_r);
            passed_bytes_r <= bytes_sum[BYTES_W] ? {BYTES_W{1'b1}} : bytes_sum[BYTES_W-1:0];
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_drop_r    <= drop_r;
            out_slot_r    <= matched_r;
            out_hits_r    <= hits_r;
            out_passed_r  <= HITS_W'(passed_total_r);
            out_bytes_r   <= passed_bytes_r;
            out_dropped_r <= HITS_W'(dropped_total_r);
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.drop_packet     = out_drop_r;
  assign out_ch.matched_slot    = out_slot_r;
  assign out_ch.hit_count       = out_hits_r;
  assign out_ch.passed_packets  = out_passed_r;
  assign out_ch.passed_bytes    = out_bytes_r;
  assign out_ch.dropped_packets = out_dropped_r;

endmodule

@@ verif/ipv4_prefix_rule_filter_test.sv @@
// Self-checking testbench for ipv4_prefix_rule_filter: directed table, then random traffic.
// Depends on iprf_pkg, the three channel interfaces and the filter top level.
module ipv4_prefix_rule_filter_test;
  import iprf_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PRINT_LIMIT = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 125;

  // One input transaction
  typedef struct packed {
    logic [1:0]          operation;
    logic [ETYPE_W-1:0]  frame_type;
    logic [ADDR_W-1:0]   source_address;
    logic [ADDR_W-1:0]   dest_address;
    logic [LEN_W-1:0]    packet_length;
    logic [SLOT_W-1:0]   slot_index;
    logic [ADDR_W-1:0]   rule_src_net;
    logic [PREFIX_W-1:0] rule_src_prefix;
    logic [ADDR_W-1:0]   rule_dst_net;
    logic [PREFIX_W-1:0] rule_dst_prefix;
    logic                rule_drops;
  } filter_item_t;

  // One result transaction
  typedef struct packed {
    logic               drop_packet;
    logic [SLOT_W-1:0]  matched_slot;
    logic [HITS_W-1:0]  hit_count;
    logic [HITS_W-1:0]  passed_packets;
    logic [BYTES_W-1:0] passed_bytes;
    logic [HITS_W-1:0]  dropped_packets;
  } filter_outcome_t;

  // Directed table row: either a register write or an item, optionally with a typed result
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    filter_item_t          item;
    bit                    typed;
    filter_outcome_t       want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;

  iprf_in_if  in_ch ();
  iprf_out_if out_ch ();
  iprf_cfg_if cfg_ch ();

  ipv4_prefix_rule_filter dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #1 clk = ~clk;

  // Shadow copy of the filter: rule table, counters, totals, registers
  rule_entry_t        rule_table [RULE_SLOTS];
  logic [HITS_W-1:0]  slot_hits [HIT_SLOTS];
  logic [HITS_W-1:0]  passed_total;
  logic [BYTES_W-1:0] passed_byte_total;
  logic [HITS_W-1:0]  dropped_total;
  logic [SLOT_W-1:0]  rule_limit;
  logic               miss_drop;

  filter_outcome_t outcomes_due [$];
  directed_row_t   directed_rows [$];

  int  mismatches;
  int  results_checked;
  int  items_sent;
  int  classify_count;
  int  rule_hit_count;
  int  write_count;
  int  read_count;
  int  cfg_writes;
  int  burst_left;
  bit  hold_off_req;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, expected %0h (result %0d)", name, got, want,
                                results_checked));
  endtask

  function automatic logic [ADDR_W-1:0] net_mask(input logic [PREFIX_W-1:0] plen);
    if (plen == 0) return '0;
    if (plen >= PREFIX_FULL) return '1;
    return ~(32'hFFFF_FFFF >> plen);
  endfunction

  function automatic logic [HITS_W-1:0] bump_count(input logic [HITS_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  // Predicts the result of one accepted transaction and advances the shadow state
  function automatic filter_outcome_t filter_step(input filter_item_t it);
    filter_outcome_t res;
    logic [BYTES_W:0] byte_sum;
    rule_entry_t      e;
    int               scan_len;
    bit               found;
    res = '0;
    res.matched_slot = SLOT_NONE;
    case (it.operation)
      OP_CLASSIFY: begin
        if (it.frame_type == ETHER_IPV4) begin
          scan_len = (rule_limit > RULE_SLOTS) ? RULE_SLOTS : int'(rule_limit);
          res.matched_slot = SLOT_DEFAULT;
          res.drop_packet = miss_drop;
          found = 1'b0;
          // first match in index order decides
          for (int i = 0; i < scan_len; i++) begin
            e = rule_table[i];
            if (!found && (it.source_address & net_mask(e.src_prefix)) == e.src_net &&
                (it.dest_address & net_mask(e.dst_prefix)) == e.dst_net) begin
              found = 1'b1;
              res.matched_slot = SLOT_W'(i);
              res.drop_packet = e.drops;
            end
          end
          if (found) rule_hit_count++;
          slot_hits[res.matched_slot] = bump_count(slot_hits[res.matched_slot]);
        end else begin
          res.drop_packet = miss_drop;
        end
        if (res.drop_packet) begin
          dropped_total = bump_count(dropped_total);
        end else begin
          passed_total = bump_count(passed_total);
          byte_sum = {1'b0, passed_byte_total} +
                     {{(BYTES_W + 1 - LEN_W){1'b0}}, it.packet_length};
          passed_byte_total = byte_sum[BYTES_W] ? '1 : byte_sum[BYTES_W-1:0];
        end
      end
      OP_WRITE_RULE: begin
        if (it.slot_index < RULE_SLOTS)
          rule_table[it.slot_index] = '{src_net: it.rule_src_net, dst_net: it.rule_dst_net,
                                        src_prefix: it.rule_src_prefix,
                                        dst_prefix: it.rule_dst_prefix,
                                        drops: it.rule_drops};
      end
      OP_READ_HITS: begin
        if (it.slot_index <= RULE_SLOTS) res.hit_count = slot_hits[it.slot_index];
      end
      default: ;
    endcase
    res.passed_packets = passed_total;
    res.passed_bytes = passed_byte_total;
    res.dropped_packets = dropped_total;
    return res;
  endfunction

  function automatic filter_outcome_t make_outcome(input logic drop, input logic [SLOT_W-1:0] slot,
                                                   input logic [HITS_W-1:0] hits,
                                                   input logic [HITS_W-1:0] passed,
                                                   input logic [BYTES_W-1:0] bytes,
                                                   input logic [HITS_W-1:0] dropped);
    filter_outcome_t o;
    o.drop_packet = drop;
    o.matched_slot = slot;
    o.hit_count = hits;
    o.passed_packets = passed;
    o.passed_bytes = bytes;
    o.dropped_packets = dropped;
    return o;
  endfunction

  // Every field random; callers override what the operation uses
  function automatic filter_item_t noise_item();
    filter_item_t it;
    it.operation = 2'($urandom);
    it.frame_type = ETYPE_W'($urandom);
    it.source_address = $urandom;
    it.dest_address = $urandom;
    it.packet_length = LEN_W'($urandom);
    it.slot_index = SLOT_W'($urandom);
    it.rule_src_net = $urandom;
    it.rule_src_prefix = PREFIX_W'($urandom);
    it.rule_dst_net = $urandom;
    it.rule_dst_prefix = PREFIX_W'($urandom);
    it.rule_drops = 1'($urandom);
    return it;
  endfunction

  function automatic filter_item_t classify_item(input logic [ETYPE_W-1:0] etype,
                                                 input logic [ADDR_W-1:0] src,
                                                 input logic [ADDR_W-1:0] dst,
                                                 input logic [LEN_W-1:0] len);
    filter_item_t it;
    it = noise_item();
    it.operation = OP_CLASSIFY;
    it.frame_type = etype;
    it.source_address = src;
    it.dest_address = dst;
    it.packet_length = len;
    return it;
  endfunction

  function automatic filter_item_t rule_item(input logic [SLOT_W-1:0] slot,
                                             input logic [ADDR_W-1:0] sn,
                                             input logic [PREFIX_W-1:0] sp,
                                             input logic [ADDR_W-1:0] dn,
                                             input logic [PREFIX_W-1:0] dp, input logic drops);
    filter_item_t it;
    it = noise_item();
    it.operation = OP_WRITE_RULE;
    it.slot_index = slot;
    it.rule_src_net = sn;
    it.rule_src_prefix = sp;
    it.rule_dst_net = dn;
    it.rule_dst_prefix = dp;
    it.rule_drops = drops;
    return it;
  endfunction

  function automatic filter_item_t read_item(input logic [SLOT_W-1:0] slot);
    filter_item_t it;
    it = noise_item();
    it.operation = OP_READ_HITS;
    it.slot_index = slot;
    return it;
  endfunction

  function automatic logic [PREFIX_W-1:0] random_prefix();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 8;
      2: return 16;
      3: return 24;
      4: return PREFIX_FULL;
      5: return PREFIX_W'($urandom_range(33, 63));
      default: return PREFIX_W'($urandom_range(1, 32));
    endcase
  endfunction

  // Mostly well-formed nets; some keep host bits so they can never match
  function automatic filter_item_t random_rule_item(input logic [SLOT_W-1:0] slot);
    filter_item_t it;
    it = rule_item(slot, $urandom, random_prefix(), $urandom, random_prefix(), 1'($urandom));
    if ($urandom_range(0, 6) != 0) it.rule_src_net &= net_mask(it.rule_src_prefix);
    if ($urandom_range(0, 6) != 0) it.rule_dst_net &= net_mask(it.rule_dst_prefix);
    return it;
  endfunction

  function automatic filter_item_t random_item();
    filter_item_t it;
    rule_entry_t  r;
    logic [ADDR_W-1:0] m;
    int pick;
    int lim;
    int k;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      it = classify_item(ETHER_IPV4, $urandom, $urandom, LEN_W'($urandom));
      case ($urandom_range(0, 19))
        0: it.frame_type = '0;
        1: it.frame_type = '1;
        2: it.frame_type = ETHER_IPV4 ^ (16'h1 << $urandom_range(0, 15));
        3: it.frame_type = ETYPE_W'($urandom);
        default: ;
      endcase
      // aim most packets at a stored rule, with random host bits
      if ($urandom_range(0, 9) < 7) begin
        lim = (rule_limit > RULE_SLOTS) ? RULE_SLOTS : int'(rule_limit);
        k = (lim > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, lim - 1)
                                                   : $urandom_range(0, RULE_SLOTS - 1);
        r = rule_table[k];
        m = net_mask(r.src_prefix);
        it.source_address = (r.src_net & m) | (it.source_address & ~m);
        m = net_mask(r.dst_prefix);
        it.dest_address = (r.dst_net & m) | (it.dest_address & ~m);
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 1)) it.source_address ^= 32'h1 << $urandom_range(0, 31);
          else it.dest_address ^= 32'h1 << $urandom_range(0, 31);
        end
      end
      case ($urandom_range(0, 9))
        0: it.packet_length = '0;
        1: it.packet_length = '1;
        default: ;
      endcase
    end else if (pick < 80) begin
      it = random_rule_item(SLOT_W'(($urandom_range(0, 9) != 0)
                                    ? $urandom_range(0, RULE_SLOTS - 1)
                                    : $urandom_range(RULE_SLOTS, 63)));
    end else if (pick < 95) begin
      it = read_item(SLOT_W'(($urandom_range(0, 6) != 0)
                             ? $urandom_range(0, RULE_SLOTS)
                             : $urandom_range(RULE_SLOTS + 1, 63)));
    end else begin
      it = noise_item();
      it.operation = OP_UNUSED;
    end
    return it;
  endfunction

  // Sends one transaction with burst pacing, then files its expected result
  task automatic offer(input filter_item_t it, input bit typed, input filter_outcome_t want);
    filter_outcome_t predicted;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) @(negedge clk) in_ch.valid <= 1'b0;
    end
    burst_left--;
    @(negedge clk);
    in_ch.operation       <= it.operation;
    in_ch.frame_type      <= it.frame_type;
    in_ch.source_address  <= it.source_address;
    in_ch.dest_address    <= it.dest_address;
    in_ch.packet_length   <= it.packet_length;
    in_ch.slot_index      <= it.slot_index;
    in_ch.rule_src_net    <= it.rule_src_net;
    in_ch.rule_src_prefix <= it.rule_src_prefix;
    in_ch.rule_dst_net    <= it.rule_dst_net;
    in_ch.rule_dst_prefix <= it.rule_dst_prefix;
    in_ch.rule_drops      <= it.rule_drops;
    in_ch.valid           <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predicted = filter_step(it);
    outcomes_due.push_back(typed ? want : predicted);
    items_sent++;
    case (it.operation)
      OP_CLASSIFY:   classify_count++;
      OP_WRITE_RULE: write_count++;
      OP_READ_HITS:  read_count++;
      default: ;
    endcase
  endtask

  // Sender pauses until every expected result is back
  task automatic wait_results_drained();
    @(negedge clk) in_ch.valid <= 1'b0;
    burst_left = 0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.reg_index <= idx;
    cfg_ch.reg_data  <= data;
    cfg_ch.valid     <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_ACTIVE_RULE_COUNT) rule_limit = data;
    else if (idx == CFG_DEFAULT_DROP) miss_drop = data[0];
    cfg_writes++;
    @(negedge clk) cfg_ch.valid <= 1'b0;
  endtask

  task automatic add_row(input filter_item_t it);
    directed_row_t row;
    row = '{is_cfg: 1'b0, cfg_idx: '0, cfg_data: '0, item: it, typed: 1'b0, want: '0};
    directed_rows.push_back(row);
  endtask

  task automatic add_typed_row(input filter_item_t it, input filter_outcome_t want);
    directed_row_t row;
    row = '{is_cfg: 1'b0, cfg_idx: '0, cfg_data: '0, item: it, typed: 1'b1, want: want};
    directed_rows.push_back(row);
  endtask

  task automatic add_cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    directed_row_t row;
    row = '{is_cfg: 1'b1, cfg_idx: idx, cfg_data: data, item: '0, typed: 1'b0, want: '0};
    directed_rows.push_back(row);
  endtask

  // Directed table: reset values, extremes, each operation and the corner cases
  task automatic build_directed_table();
    filter_item_t unused_op;
    unused_op = '1;
    unused_op.operation = OP_UNUSED;
    // counters and totals straight after reset
    add_typed_row(read_item(SLOT_DEFAULT), make_outcome(0, SLOT_NONE, 0, 0, 0, 0));
    add_typed_row(unused_op, make_outcome(0, SLOT_NONE, 0, 0, 0, 0));
    // non-IPv4 frame passes by default, counts no hit
    add_typed_row(classify_item(16'h86DD, $urandom, $urandom, 16'd100),
                  make_outcome(0, SLOT_NONE, 0, 1, 100, 0));
    // no active rules: default slot, longest packet
    add_typed_row(classify_item(ETHER_IPV4, '0, '1, '1),
                  make_outcome(0, SLOT_DEFAULT, 0, 2, 65635, 0));
    add_typed_row(read_item(SLOT_DEFAULT), make_outcome(0, SLOT_NONE, 1, 2, 65635, 0));
    // read beyond the default slot gives zero
    add_typed_row(read_item('1), make_outcome(0, SLOT_NONE, 0, 2, 65635, 0));
    // rules: plain /8 and /24, full /32 extremes, net with host bits, overlong prefix
    add_row(rule_item(0, 32'h0A00_0000, 8, 32'hC0A8_0100, 24, 1'b1));
    add_row(rule_item(1, 32'hFFFF_FFFF, PREFIX_FULL, 32'h0000_0000, PREFIX_FULL, 1'b0));
    add_row(rule_item(2, 32'h0A00_0001, 8, 32'h0000_0000, 0, 1'b0));
    add_row(rule_item(3, 32'h1234_5678, '1, 32'h0000_0000, 0, 1'b1));
    // writes to slots past the table are dropped
    add_row(rule_item(SLOT_DEFAULT, '0, 0, '0, 0, 1'b1));
    add_row(rule_item('1, '0, 0, '0, 0, 1'b1));
    add_cfg_row(CFG_ACTIVE_RULE_COUNT, 4);
    add_row(classify_item(ETHER_IPV4, 32'h0A12_3456, 32'hC0A8_01FE, 16'd64));
    add_row(classify_item(ETHER_IPV4, 32'hFFFF_FFFF, 32'h0000_0000, 16'd1500));
    add_row(classify_item(ETHER_IPV4, 32'h0A00_0001, 32'h0000_0000, 16'd40));
    add_row(classify_item(ETHER_IPV4, 32'h1234_5678, 32'hDEAD_BEEF, 16'd0));
    add_row(classify_item(16'h0801, 32'h0A12_3456, 32'hC0A8_01FE, 16'd60));
    add_cfg_row(CFG_DEFAULT_DROP, 1);
    add_row(classify_item(ETHER_IPV4, 32'h0B00_0000, 32'hC0A8_0101, 16'd90));
    add_row(classify_item('1, 32'h0A12_3456, 32'hC0A8_01FE, '1));
    add_row(read_item(0));
    add_row(read_item(3));
    add_row(read_item(SLOT_NONE));
    add_row(rule_item(SLOT_W'(RULE_SLOTS - 1), 32'hAC10_2000, 24, 32'hAC10_0000, 12, 1'b0));
    add_row(classify_item('0, '1, '1, 16'd1));
  endtask

  // Result side: stall pattern of its own plus one long hold-off on request
  initial begin : result_sink
    int hold_left;
    int tick;
    hold_left = 0;
    tick = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case ((tick / 97) % 4)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= ((tick % 7) < 3);
          default: out_ch.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    filter_outcome_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch("result with no transaction pending");
      end else begin
        want = outcomes_due.pop_front();
        check_field("drop_packet", 64'(out_ch.drop_packet), 64'(want.drop_packet));
        check_field("matched_slot", 64'(out_ch.matched_slot), 64'(want.matched_slot));
        check_field("hit_count", 64'(out_ch.hit_count), 64'(want.hit_count));
        check_field("passed_packets", 64'(out_ch.passed_packets), 64'(want.passed_packets));
        check_field("passed_bytes", out_ch.passed_bytes, want.passed_bytes);
        check_field("dropped_packets", 64'(out_ch.dropped_packets),
                    64'(want.dropped_packets));
        results_checked++;
      end
    end
  end

  initial begin : stimulus
    logic [SLOT_W-1:0] limit_sel;
    logic              drop_sel;
    // drive every input before reset
    rst_n = 1'b0;
    hold_off_req = 1'b0;
    burst_left = 0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_CLASSIFY;
    in_ch.frame_type = '0;
    in_ch.source_address = '0;
    in_ch.dest_address = '0;
    in_ch.packet_length = '0;
    in_ch.slot_index = '0;
    in_ch.rule_src_net = '0;
    in_ch.rule_src_prefix = '0;
    in_ch.rule_dst_net = '0;
    in_ch.rule_dst_prefix = '0;
    in_ch.rule_drops = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = CFG_ACTIVE_RULE_COUNT;
    cfg_ch.reg_data = '0;
    foreach (rule_table[i]) rule_table[i] = '0;
    foreach (slot_hits[i]) slot_hits[i] = '0;
    passed_total = '0;
    passed_byte_total = '0;
    dropped_total = '0;
    rule_limit = '0;
    miss_drop = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    write_register(CFG_ACTIVE_RULE_COUNT, 0);
    write_register(CFG_DEFAULT_DROP, 0);

    build_directed_table();
    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        wait_results_drained();
        write_register(directed_rows[r].cfg_idx, directed_rows[r].cfg_data);
      end else begin
        offer(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    // fill every slot so any rule count is legal from here on
    for (int s = 0; s < RULE_SLOTS; s++) offer(random_rule_item(SLOT_W'(s)), 1'b0, '0);

    for (int p = 0; p < PHASES; p++) begin
      wait_results_drained();
      case (p)
        0: begin limit_sel = SLOT_DEFAULT; drop_sel = 1'b0; end
        1: begin limit_sel = '1;           drop_sel = 1'b1; end
        2: begin limit_sel = '0;           drop_sel = 1'b0; end
        3: begin limit_sel = 1;            drop_sel = 1'b1; end
        default: begin limit_sel = SLOT_W'($urandom); drop_sel = 1'($urandom); end
      endcase
      write_register(CFG_ACTIVE_RULE_COUNT, limit_sel);
      write_register(CFG_DEFAULT_DROP, {(CFG_DATA_W - 1)'($urandom_range(0, 31)), drop_sel});
      // writes to unused register indexes change nothing
      if ($urandom_range(0, 2) == 0)
        write_register(CFG_IDX_W'($urandom_range(CFG_DEFAULT_DROP + 1, (1 << CFG_IDX_W) - 1)),
                       CFG_DATA_W'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == 20) hold_off_req = 1'b1;
        if (p == 6 && n == 60) wait_results_drained();
        offer(random_item(), 1'b0, '0);
      end
    end

    wait_results_drained();
    repeat (50) @(posedge clk);
    if (outcomes_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", outcomes_due.size()));

    $display("covered %0d items: %0d classify (%0d rule hits), %0d rule writes, %0d hit reads",
             items_sent, classify_count, rule_hit_count, write_count, read_count);
    $display("%0d register writes, %0d results checked, %0d mismatches",
             cfg_writes, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run
  initial begin : watchdog
    #1000000;
    $display("timeout with %0d results outstanding", outcomes_due.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
